// ===== design/dspu_pkg.sv =====
// dspu_pkg: shared types, constants and arithmetic helpers of the synapse psr update block
`timescale 1ns / 1ps

package dspu_pkg;

  // fixed-point format of the block's values; e^-1 below is in Q32 instead
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned UNIT_W    = 25;

  localparam logic [UNIT_W-1:0] FX_ONE = UNIT_W'(64'd1 << FRAC_BITS);

  // e^-1 in Q32
  localparam logic [30:0] E_INV_Q32 = 31'd1580030169;

  // class constants U, D, F rounded to nearest
  localparam logic [UNIT_W-1:0] U_II = UNIT_W'(((64'd32 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [UNIT_W-1:0] D_II = UNIT_W'(((64'd144 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [UNIT_W-1:0] F_II = UNIT_W'(((64'd6 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [UNIT_W-1:0] U_IE = UNIT_W'(((64'd1 << FRAC_BITS) + 64'd2) / 64'd4);
  localparam logic [UNIT_W-1:0] D_IE = UNIT_W'(((64'd7 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [UNIT_W-1:0] F_IE = UNIT_W'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [UNIT_W-1:0] U_EI = UNIT_W'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [UNIT_W-1:0] D_EI = UNIT_W'(((64'd1 << FRAC_BITS) + 64'd4) / 64'd8);
  localparam logic [UNIT_W-1:0] F_EI = UNIT_W'(((64'd12 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [UNIT_W-1:0] U_EE = UNIT_W'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd2);
  localparam logic [UNIT_W-1:0] D_EE = UNIT_W'(((64'd11 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [UNIT_W-1:0] F_EE = UNIT_W'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);

  // configuration register indexes
  localparam logic [0:0] CFG_STEP_DURATION = 1'b0;
  localparam logic [0:0] CFG_DEFAULT_USE   = 1'b1;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_RESET  = 2'd1,
    OP_SPIKE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CLS_II = 2'd0,
    CLS_IE = 2'd1,
    CLS_EI = 2'd2,
    CLS_EE = 2'd3
  } cls_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PEEK, ST_LOAD, ST_ISI, ST_ISIL, ST_ECHK, ST_EDIV, ST_TMUL, ST_TDIVI,
    ST_TDIV, ST_TACC, ST_EPOW, ST_EPW2, ST_EFIN, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5,
    ST_QCHK, ST_QDIV, ST_M1, ST_M2, ST_M3, ST_OUT
  } st_e;

  // per-synapse dynamic state
  typedef struct packed {
    logic                    spiked;
    logic [31:0]             last;
    logic [UNIT_W-1:0]       res;
    logic [UNIT_W-1:0]       use_v;
    logic signed [31:0]      psr;
  } dyn_t;

  // per-synapse constants written on create
  typedef struct packed {
    logic signed [31:0]      weight;
    logic [30:0]             decay;
    logic [UNIT_W-1:0]       base_use;
    logic [UNIT_W-1:0]       dtau;
    logic [UNIT_W-1:0]       ftau;
  } prm_t;

  typedef struct packed {
    logic [UNIT_W-1:0]       base_use;
    logic [UNIT_W-1:0]       dtau;
    logic [UNIT_W-1:0]       ftau;
  } cls_t;

  // divider request and response
  typedef struct packed {
    logic                    start;
    logic [31:0]             divisor;
    logic [31:0]             rem0;
    logic [31:0]             low;
    logic [4:0]              iters;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [31:0]             quot;
  } div_rsp_t;

  function automatic cls_t class_consts(input cls_e cls);
    cls_t c;
    case (cls)
      CLS_II:  c = '{base_use: U_II, dtau: D_II, ftau: F_II};
      CLS_IE:  c = '{base_use: U_IE, dtau: D_IE, ftau: F_IE};
      CLS_EI:  c = '{base_use: U_EI, dtau: D_EI, ftau: F_EI};
      CLS_EE:  c = '{base_use: U_EE, dtau: D_EE, ftau: F_EE};
      default: c = '{base_use: U_II, dtau: D_II, ftau: F_II};
    endcase
    return c;
  endfunction

  // round a product to nearest (ties away from zero) and saturate to 32 bits
  function automatic logic signed [31:0] fx_round(input logic signed [67:0] p);
    logic [67:0] mag;
    logic [67:0] rnd;
    logic [43:0] r;
    logic signed [31:0] res;
    mag = p[67] ? 68'(-p) : 68'(p);
    rnd = mag + (68'd1 << (FRAC_BITS - 1));
    r   = 44'(rnd >> FRAC_BITS);
    if (p[67]) begin
      if (r > 44'd2147483648) res = 32'sh8000_0000;
      else res = 32'(-$signed({1'b0, r}));
    end else begin
      if (r > 44'd2147483647) res = 32'sh7fff_ffff;
      else res = 32'(r);
    end
    return res;
  endfunction

  // clamp to [0, 1]
  function automatic logic [UNIT_W-1:0] sat_unit(input logic signed [33:0] v);
    logic [UNIT_W-1:0] res;
    if (v[33]) res = '0;
    else if (v > $signed({9'd0, FX_ONE})) res = FX_ONE;
    else res = UNIT_W'(v);
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] res;
    if (v > 33'sd2147483647) res = 32'sh7fff_ffff;
    else if (v < -33'sd2147483648) res = 32'sh8000_0000;
    else res = 32'(v);
    return res;
  endfunction

  // eight bits of long division by a small divisor: {remainder, quotient byte}
  function automatic logic [11:0] div_small(input logic [3:0] rem, input logic [7:0] bits,
                                            input logic [3:0] k);
    logic [4:0] t;
    logic [3:0] r;
    logic [7:0] q;
    r = rem;
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, k}) begin
        t = t - {1'b0, k};
        q[i] = 1'b1;
      end
      r = t[3:0];
    end
    return {r, q};
  endfunction

endpackage

// ===== design/dspu_div.sv =====
// dspu_div: shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module dspu_div
  import dspu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] low_q, low_d;
  logic [31:0] quot_q, quot_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;
  logic        fits;

  // one trial subtraction
  assign trial = {rem_q, low_q[31]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      rem_d  = req_i.rem0;
      low_d  = req_i.low;
      quot_d = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = fits ? 32'(trial - {1'b0, dvs_q}) : 32'(trial);
      low_d  = {low_q[30:0], 1'b0};
      quot_d = {quot_q[30:0], fits};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o = '{done: done_q, quot: quot_q};

endmodule

// ===== design/dynamic_synapse_psr_update_core.sv =====
// dynamic_synapse_psr_update_core: short-term plasticity synapse table with psr update
`timescale 1ns / 1ps

// Synapse table with Tsodyks-Markram short-term plasticity. Each word on the input stream
// (op in tuser) creates, resets, spikes or (op 3) reads one entry and yields exactly one
// result word with the entry's psr, r and u afterwards; an out-of-range index yields zeros.
// Words are handled one at a time. A spike on an entry that spiked before computes two
// exponentials, each a division on the shared divider, 12 Taylor terms on the shared
// multiplier and small divider, and one multiply by e^-1 per whole unit of interval over
// tau (up to 31). The weight to decay division runs on the same shared divider. Entry
// state lives in two single-port memories with registered reads; no clearing pass is
// needed after reset. A finished result waits in the output register while the next word
// is accepted.

module dynamic_synapse_psr_update_core
  import dspu_pkg::*;
#(
  parameter int unsigned NUM_SYNAPSES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // edge_index, syn_type, sim_step, weight, decay_factor (lowest first), zero padded
  input  logic [111:0] s_axis_tdata,
  // op
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // psr_out, resource_out, use_out (lowest first), zero padded
  output logic [87:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_addr_i,
  input  logic [30:0]  cfg_data_i
);

  localparam int unsigned AW  = (NUM_SYNAPSES > 1) ? $clog2(NUM_SYNAPSES) : 1;
  localparam int unsigned NB  = 5;
  localparam int unsigned QSH = 31 - FRAC_BITS;
  localparam int unsigned QW  = 31 + QSH;
  localparam int unsigned SDW = 40;

  // input word fields
  logic [9:0]         in_edge;
  cls_e               in_cls;
  logic [31:0]        in_step;
  logic signed [31:0] in_weight;
  logic [30:0]        in_decay;
  op_e                in_op;
  logic               in_acc;
  logic               in_range;

  assign in_edge   = s_axis_tdata[9:0];
  assign in_cls    = cls_e'(s_axis_tdata[11:10]);
  assign in_step   = s_axis_tdata[43:12];
  assign in_weight = s_axis_tdata[75:44];
  assign in_decay  = s_axis_tdata[106:76];
  assign in_op     = op_e'(s_axis_tuser);
  assign in_range  = {22'd0, in_edge} < 32'(NUM_SYNAPSES);

  st_e state_q, state_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // configuration registers
  logic [30:0]       step_dur_q;
  logic [UNIT_W-1:0] def_use_q;
  logic [UNIT_W-1:0] def_use_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_dur_q <= 31'd1677;
      def_use_q  <= 25'd8388608;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_STEP_DURATION: step_dur_q <= cfg_data_i;
        CFG_DEFAULT_USE:   def_use_q  <= cfg_data_i[UNIT_W-1:0];
        default:           ;
      endcase
    end
  end

  assign def_use_sat = (def_use_q > FX_ONE) ? FX_ONE : def_use_q;

  // entry memories
  dyn_t          dyn_mem [NUM_SYNAPSES];
  prm_t          prm_mem [NUM_SYNAPSES];
  dyn_t          dyn_rd_q, dyn_wdata;
  prm_t          prm_rd_q, prm_wdata;
  logic          dyn_we, dyn_re, prm_we, prm_re;
  logic [AW-1:0] idx_q, mem_addr;

  assign mem_addr = (state_q == ST_IDLE) ? AW'(in_edge) : idx_q;

  always_ff @(posedge clk_i) begin
    if (dyn_we) dyn_mem[mem_addr] <= dyn_wdata;
    if (dyn_re) dyn_rd_q <= dyn_mem[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prm_we) prm_mem[mem_addr] <= prm_wdata;
    if (prm_re) prm_rd_q <= prm_mem[mem_addr];
  end

  // shared multiplier, product registered
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p_q;
  logic signed [31:0] fx_p;
  logic signed [33:0] fx_p_x;

  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_a * mul_b;
  end

  assign fx_p   = fx_round(mul_p_q);
  assign fx_p_x = {{2{fx_p[31]}}, fx_p};

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  dspu_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // working registers
  logic [31:0]        now_q;
  logic [62:0]        isi_q;
  logic               tsel_q;
  logic [UNIT_W-1:0]  r_q, u_q, ed_q, ef_q;
  logic [NB-1:0]      n_q;
  logic [31:0]        f32_q;
  logic [32:0]        term_q;
  logic signed [34:0] sum_q, sum_nx;
  logic [3:0]         k_q;
  logic [SDW-1:0]     sdv_q;
  logic [3:0]         sdr_q;
  logic [2:0]         sdc_q;
  logic [11:0]        sd_step;
  logic [32:0]        v_q;
  logic [67:0]        v_rnd;
  logic [33:0]        e_rnd;
  logic [UNIT_W-1:0]  e_val;
  logic signed [31:0] q_q;
  logic signed [31:0] psr_new;

  // output staging
  logic signed [31:0] pend_psr_q, out_psr_q;
  logic [UNIT_W-1:0]  pend_r_q, pend_u_q, out_r_q, out_u_q;
  logic               out_valid_q;
  logic               out_load;

  // exponential and quotient helpers
  logic [UNIT_W-1:0]  tau;
  logic               exp_big;
  logic               w_neg;
  logic [32:0]        w_mag33;
  logic [31:0]        w_mag;
  logic               q_sat;
  logic [31:0]        diff;

  assign tau     = tsel_q ? prm_rd_q.ftau : prm_rd_q.dtau;
  assign exp_big = isi_q >= (63'(tau) << NB);
  assign w_neg   = prm_rd_q.weight[31];
  assign w_mag33 = w_neg ? 33'(-$signed({prm_rd_q.weight[31], prm_rd_q.weight}))
                         : 33'(prm_rd_q.weight);
  assign w_mag   = w_mag33[31:0];
  assign q_sat   = QW'(w_mag) >= (QW'(prm_rd_q.decay) << QSH);
  assign diff    = now_q - dyn_rd_q.last;
  assign sd_step = div_small(sdr_q, sdv_q[SDW-1:SDW-8], k_q);
  assign sum_nx  = k_q[0] ? sum_q - $signed({2'b0, sdv_q[32:0]})
                          : sum_q + $signed({2'b0, sdv_q[32:0]});
  assign v_rnd   = 68'(mul_p_q) + (68'd1 << 31);
  assign e_rnd   = ({1'b0, v_q} + (34'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  assign e_val   = UNIT_W'(e_rnd);
  assign psr_new = sat32({dyn_rd_q.psr[31], dyn_rd_q.psr} + {fx_p[31], fx_p});

  // next state, memory control, multiplier and divider operands
  always_comb begin
    state_d   = state_q;
    dyn_we    = 1'b0;
    dyn_re    = 1'b0;
    prm_we    = 1'b0;
    prm_re    = 1'b0;
    dyn_wdata = '{spiked: 1'b0, last: '0, res: FX_ONE, use_v: def_use_sat, psr: '0};
    prm_wdata = '{weight: in_weight, decay: in_decay,
                  base_use: class_consts(in_cls).base_use,
                  dtau: class_consts(in_cls).dtau, ftau: class_consts(in_cls).ftau};
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_range) begin
            state_d = ST_OUT;
          end else begin
            case (in_op)
              OP_CREATE: begin
                prm_we  = 1'b1;
                dyn_we  = 1'b1;
                state_d = ST_OUT;
              end
              OP_RESET: begin
                dyn_we  = 1'b1;
                state_d = ST_OUT;
              end
              OP_SPIKE: begin
                dyn_re  = 1'b1;
                prm_re  = 1'b1;
                state_d = ST_LOAD;
              end
              default: begin
                dyn_re  = 1'b1;
                state_d = ST_PEEK;
              end
            endcase
          end
        end
      end
      ST_PEEK: state_d = ST_OUT;
      ST_LOAD: state_d = dyn_rd_q.spiked ? ST_ISI : ST_QCHK;
      ST_ISI: begin
        mul_a   = 34'(diff);
        mul_b   = 34'(step_dur_q);
        state_d = ST_ISIL;
      end
      ST_ISIL: state_d = ST_ECHK;
      ST_ECHK: begin
        if (exp_big) begin
          state_d = tsel_q ? ST_R1 : ST_ECHK;
        end else begin
          div_req = '{start: 1'b1, divisor: 32'(tau), rem0: 32'(isi_q >> NB),
                      low: 32'(isi_q[NB-1:0]) << (32 - NB), iters: 5'(NB + FRAC_BITS)};
          state_d = ST_EDIV;
        end
      end
      ST_EDIV: if (div_rsp.done) state_d = ST_TMUL;
      ST_TMUL: begin
        mul_a   = 34'(term_q);
        mul_b   = 34'(f32_q);
        state_d = ST_TDIVI;
      end
      ST_TDIVI: state_d = ST_TDIV;
      ST_TDIV:  if (sdc_q == 3'(SDW / 8 - 1)) state_d = ST_TACC;
      ST_TACC:  state_d = (k_q == 4'd12) ? ST_EPOW : ST_TMUL;
      ST_EPOW: begin
        if (n_q == '0) begin
          state_d = ST_EFIN;
        end else begin
          mul_a   = 34'(v_q);
          mul_b   = 34'(E_INV_Q32);
          state_d = ST_EPW2;
        end
      end
      ST_EPW2: state_d = ST_EPOW;
      ST_EFIN: state_d = tsel_q ? ST_R1 : ST_ECHK;
      ST_R1: begin
        mul_a   = 34'(r_q);
        mul_b   = 34'(FX_ONE) - 34'(u_q);
        state_d = ST_R2;
      end
      ST_R2: begin
        mul_a   = fx_p_x - 34'(FX_ONE);
        mul_b   = 34'(ed_q);
        state_d = ST_R3;
      end
      ST_R3: begin
        mul_a   = 34'(u_q);
        mul_b   = 34'(FX_ONE) - 34'(prm_rd_q.base_use);
        state_d = ST_R4;
      end
      ST_R4: begin
        mul_a   = fx_p_x;
        mul_b   = 34'(ef_q);
        state_d = ST_R5;
      end
      ST_R5: state_d = ST_QCHK;
      ST_QCHK: begin
        if (w_mag == '0 || q_sat) begin
          state_d = ST_M1;
        end else begin
          div_req = '{start: 1'b1, divisor: 32'(prm_rd_q.decay), rem0: 32'(w_mag >> QSH),
                      low: 32'(w_mag[QSH-1:0]) << (32 - QSH), iters: 5'd31};
          state_d = ST_QDIV;
        end
      end
      ST_QDIV: if (div_rsp.done) state_d = ST_M1;
      ST_M1: begin
        mul_a   = {{2{q_q[31]}}, q_q};
        mul_b   = 34'(u_q);
        state_d = ST_M2;
      end
      ST_M2: begin
        mul_a   = fx_p_x;
        mul_b   = 34'(r_q);
        state_d = ST_M3;
      end
      ST_M3: begin
        dyn_we    = 1'b1;
        dyn_wdata = '{spiked: 1'b1, last: now_q, res: r_q, use_v: u_q, psr: psr_new};
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        idx_q <= AW'(in_edge);
        now_q <= in_step;
        if (!in_range) begin
          pend_psr_q <= '0;
          pend_r_q   <= '0;
          pend_u_q   <= '0;
        end else begin
          pend_psr_q <= '0;
          pend_r_q   <= FX_ONE;
          pend_u_q   <= def_use_sat;
        end
      end
      ST_PEEK: begin
        pend_psr_q <= dyn_rd_q.psr;
        pend_r_q   <= dyn_rd_q.res;
        pend_u_q   <= dyn_rd_q.use_v;
      end
      ST_LOAD: begin
        r_q <= dyn_rd_q.res;
        u_q <= dyn_rd_q.use_v;
      end
      ST_ISIL: begin
        isi_q  <= mul_p_q[62:0];
        tsel_q <= 1'b0;
      end
      ST_ECHK: begin
        if (exp_big) begin
          if (tsel_q) ef_q <= '0;
          else ed_q <= '0;
          tsel_q <= 1'b1;
        end
      end
      ST_EDIV: begin
        n_q    <= div_rsp.quot[NB+FRAC_BITS-1:FRAC_BITS];
        f32_q  <= 32'(div_rsp.quot[FRAC_BITS-1:0]) << (32 - FRAC_BITS);
        term_q <= 33'd1 << 32;
        sum_q  <= 35'sd1 <<< 32;
        k_q    <= 4'd1;
      end
      ST_TDIVI: begin
        sdv_q <= SDW'(mul_p_q[64:32]);
        sdr_q <= '0;
        sdc_q <= '0;
      end
      ST_TDIV: begin
        sdr_q <= sd_step[11:8];
        sdv_q <= {sdv_q[SDW-9:0], sd_step[7:0]};
        sdc_q <= sdc_q + 3'd1;
      end
      ST_TACC: begin
        term_q <= sdv_q[32:0];
        sum_q  <= sum_nx;
        v_q    <= 33'(sum_nx);
        k_q    <= k_q + 4'd1;
      end
      ST_EPW2: begin
        v_q <= 33'(v_rnd >> 32);
        n_q <= n_q - NB'(1);
      end
      ST_EFIN: begin
        if (tsel_q) ef_q <= e_val;
        else ed_q <= e_val;
        tsel_q <= 1'b1;
      end
      ST_R3: r_q <= sat_unit(fx_p_x + 34'(FX_ONE));
      ST_R5: u_q <= sat_unit(fx_p_x + 34'(prm_rd_q.base_use));
      ST_QCHK: begin
        if (w_mag == '0) q_q <= '0;
        else if (q_sat) q_q <= w_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      ST_QDIV: begin
        if (div_rsp.done) begin
          q_q <= w_neg ? 32'(-$signed({1'b0, div_rsp.quot[30:0]}))
                       : 32'(div_rsp.quot[30:0]);
        end
      end
      ST_M3: begin
        pend_psr_q <= psr_new;
        pend_r_q   <= r_q;
        pend_u_q   <= u_q;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_psr_q <= pend_psr_q;
      out_r_q   <= pend_r_q;
      out_u_q   <= pend_u_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_u_q, out_r_q, out_psr_q};

endmodule

// ===== tb/dynamic_synapse_psr_update_core_test.sv =====
// dynamic_synapse_psr_update_core_test: self-checking stream testbench of the synapse psr update core
`timescale 1ns / 1ps

module dynamic_synapse_psr_update_core_test;
  import dspu_pkg::*;

  localparam int unsigned NSYN = 1024;
  localparam int unsigned WATCHDOG_MAX = 20000;

  typedef struct packed {
    logic [30:0] decay;
    logic [31:0] weight;
    logic [31:0] step;
    logic [1:0]  cls;
    logic [9:0]  idx;
  } syn_word_t;

  typedef struct {
    op_e       op;
    syn_word_t w;
  } syn_cmd_t;

  typedef struct packed {
    logic [24:0] use_v;
    logic [24:0] res;
    logic [31:0] psr;
  } syn_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_addr_i = '0;
  logic [30:0] cfg_data_i = '0;

  dynamic_synapse_psr_update_core #(.NUM_SYNAPSES(NSYN)) dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [31:0] m_step_dur;
  logic [24:0] m_def_use;
  bit          m_spiked [NSYN];
  logic [31:0] m_last [NSYN];
  longint      m_res [NSYN], m_use [NSYN], m_bu [NSYN], m_dt [NSYN], m_ft [NSYN];
  longint      m_wt [NSYN], m_dec [NSYN], m_psr [NSYN];
  bit          created [NSYN];

  syn_cmd_t    pending_words[$];
  syn_result_t expected_results[$];
  int  errors = 0;
  bit  idle_ok = 1'b1;
  int  accepted = 0;
  int  stall_free = 0;
  int  quiet_cycles = 0;

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > (64'sd1 << 24)) return 64'sd1 << 24;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    longint unsigned mag;
    longint r;
    p = a * b;
    mag = p < 0 ? longint'(-p) : p;
    r = longint'((mag + (64'd1 << 23)) >> 24);
    return sat_s32(p < 0 ? -r : r);
  endfunction

  // exp(-isi/tau), Taylor series on the fraction then e^-1 per whole unit
  function automatic longint decay_factor(longint unsigned isi, longint unsigned tau);
    longint unsigned n, rem, frac, f32, term, v;
    longint sum;
    if (tau == 0) return 0;
    n = isi / tau;
    if (n >= 32) return 0;
    rem = isi % tau;
    frac = (rem << 24) / tau;
    f32 = frac << 8;
    term = 64'd1 << 32;
    sum = term;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * f32) >> 32) / k;
      sum += (k % 2) ? -longint'(term) : longint'(term);
    end
    v = sum;
    for (int k = 0; k < n; k++) v = (v * 64'd1580030169 + (64'd1 << 31)) >> 32;
    return longint'((v + (64'd1 << 7)) >> 8);
  endfunction

  function automatic longint ratio(longint num, longint den);
    return ((num << 24) + den / 2) / den;
  endfunction

  function automatic void clear_entry(int e);
    m_use[e] = clamp_unit(m_def_use);
    m_res[e] = 64'sd1 << 24;
    m_spiked[e] = 0;
    m_last[e] = '0;
    m_psr[e] = 0;
  endfunction

  function automatic syn_result_t apply_synapse_word(syn_cmd_t c);
    syn_result_t o;
    int e;
    longint r, u, bu, q, ed, ef, rn, un;
    longint unsigned isi, mag;
    e = int'(c.w.idx);
    case (c.op)
      OP_CREATE: begin
        m_wt[e] = $signed(c.w.weight);
        m_dec[e] = c.w.decay;
        case (cls_e'(c.w.cls))
          CLS_II: begin m_bu[e] = ratio(32, 100); m_dt[e] = ratio(144, 1000); m_ft[e] = ratio(6, 100); end
          CLS_IE: begin m_bu[e] = ratio(1, 4); m_dt[e] = ratio(7, 10); m_ft[e] = ratio(2, 100); end
          CLS_EI: begin m_bu[e] = ratio(5, 100); m_dt[e] = ratio(1, 8); m_ft[e] = ratio(12, 10); end
          default: begin m_bu[e] = ratio(1, 2); m_dt[e] = ratio(11, 10); m_ft[e] = ratio(5, 100); end
        endcase
        clear_entry(e);
      end
      OP_RESET: clear_entry(e);
      OP_SPIKE: begin
        r = m_res[e];
        u = m_use[e];
        bu = m_bu[e];
        if (m_spiked[e]) begin
          isi = longint'(32'(c.w.step - m_last[e])) * longint'(m_step_dur);
          ed = decay_factor(isi, m_dt[e]);
          ef = decay_factor(isi, m_ft[e]);
          rn = qmul(qmul(r, sat_s32((64'sd1 << 24) - u)) - (64'sd1 << 24), ed);
          un = qmul(qmul(u, sat_s32((64'sd1 << 24) - bu)), ef);
          r = clamp_unit((64'sd1 << 24) + rn);
          u = clamp_unit(bu + un);
          m_res[e] = r;
          m_use[e] = u;
        end
        if (m_dec[e] == 0) q = m_wt[e] > 0 ? 64'sd2147483647 : (m_wt[e] < 0 ? -64'sd2147483648 : 0);
        else begin
          mag = (m_wt[e] < 0 ? -m_wt[e] : m_wt[e]) << 24;
          q = longint'(mag / m_dec[e]);
          q = sat_s32(m_wt[e] < 0 ? -q : q);
        end
        m_psr[e] = sat_s32(m_psr[e] + qmul(qmul(q, u), r));
        m_last[e] = c.w.step;
        m_spiked[e] = 1;
      end
      default: ;
    endcase
    o.psr = m_psr[e][31:0];
    o.res = m_res[e][24:0];
    o.use_v = m_use[e][24:0];
    return o;
  endfunction

  // driver: next word goes out once the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() > 0 && (stall_free > 0 || $urandom_range(99) >= 26)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_words[0].op;
          s_axis_tdata <= {5'd0, pending_words[0].w};
          expected_results.push_back(apply_synapse_word(pending_words.pop_front()));
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= (stall_free > 0) || ($urandom_range(99) >= 26);
      if (stall_free > 0) stall_free <= stall_free - 1;
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    syn_result_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) accepted <= accepted + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[81:0];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.psr !== want.psr) begin
            $display("%0t: psr expected %h actual %h", $time, want.psr, got.psr);
            errors++;
          end
          if (got.res !== want.res) begin
            $display("%0t: r expected %h actual %h", $time, want.res, got.res);
            errors++;
          end
          if (got.use_v !== want.use_v) begin
            $display("%0t: u expected %h actual %h", $time, want.use_v, got.use_v);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic push_word(op_e op, int idx, int cls, logic [31:0] step, logic [31:0] wt,
                           logic [30:0] dec);
    syn_cmd_t c;
    c.op = op;
    c.w.idx = 10'(idx);
    c.w.cls = 2'(cls);
    c.w.step = step;
    c.w.weight = wt;
    c.w.decay = dec;
    pending_words.push_back(c);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_STEP_DURATION) m_step_dur = 32'(val);
    else m_def_use = val[24:0];
  endtask

  // random synapse traffic: mostly create then spike trains on a pool of the given size
  task automatic random_phase(int count, int pool);
    int idx;
    int n;
    logic [31:0] step;
    n = 0;
    while (n < count) begin
      idx = $urandom_range(pool - 1);
      if (!created[idx] || $urandom_range(9) == 0) begin
        push_word(OP_CREATE, idx, $urandom_range(3), $urandom,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0200_0000) - 32'h0100_0000,
                  31'($urandom_range(7) == 0 ? $urandom_range(1) : ($urandom_range(3) == 0 ?
                  $urandom : $urandom_range(32'h0400_0000, 32'h0001_0000))));
        created[idx] = 1;
      end else begin
        case ($urandom_range(19))
          0: push_word(OP_RESET, idx, $urandom_range(3), $urandom, $urandom, 31'($urandom));
          1: push_word(op_e'(2'd3), idx, $urandom_range(3), $urandom, $urandom, 31'($urandom));
          default: begin
            step = m_last[idx] + ($urandom_range(15) == 0 ? $urandom : $urandom_range(40000));
            push_word(OP_SPIKE, idx, $urandom_range(3), step, $urandom, 31'($urandom));
          end
        endcase
      end
      n++;
    end
  endtask

  initial begin
    m_step_dur = 32'd1677;
    m_def_use = 25'd8388608;
    for (int i = 0; i < NSYN; i++) begin
      m_spiked[i] = 0; m_last[i] = 0; m_res[i] = 0; m_use[i] = 0; m_bu[i] = 0;
      m_dt[i] = 0; m_ft[i] = 0; m_wt[i] = 0; m_dec[i] = 0; m_psr[i] = 0; created[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: classes, extreme weights and decays, zero decay, wrap, op 3, far index
    push_word(OP_CREATE, 0, CLS_II, 32'd0, 32'h7fff_ffff, 31'd1);
    push_word(OP_CREATE, 1023, CLS_IE, 32'hffff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    push_word(OP_CREATE, 5, CLS_EI, 32'd0, 32'h0100_0000, 31'd0);
    push_word(OP_CREATE, 6, CLS_EE, 32'd0, 32'h0000_0000, 31'd0);
    push_word(OP_CREATE, 7, CLS_EE, 32'd0, 32'hff00_0000, 31'd0);
    push_word(OP_CREATE, 8, CLS_II, 32'd0, 32'h0080_0000, 31'h0100_0000);
    push_word(OP_SPIKE, 0, CLS_II, 32'd10, '0, '0);
    push_word(OP_SPIKE, 0, CLS_II, 32'd20, '0, '0);
    push_word(OP_SPIKE, 1023, CLS_II, 32'hffff_ffff, '0, '0);
    push_word(OP_SPIKE, 1023, CLS_II, 32'd3, '0, '0);
    push_word(OP_SPIKE, 5, CLS_II, 32'd1, '0, '0);
    push_word(OP_SPIKE, 6, CLS_II, 32'd1, '0, '0);
    push_word(OP_SPIKE, 7, CLS_II, 32'd1, '0, '0);
    push_word(OP_SPIKE, 8, CLS_II, 32'd100, '0, '0);
    push_word(OP_SPIKE, 8, CLS_II, 32'd90, '0, '0);
    push_word(OP_SPIKE, 8, CLS_II, 32'd91, '0, '0);
    push_word(op_e'(2'd3), 8, CLS_EE, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
    push_word(OP_RESET, 8, CLS_II, '0, '0, '0);
    push_word(OP_SPIKE, 8, CLS_II, 32'd5, '0, '0);
    for (int i = 0; i < 9; i++) created[i] = 1;
    created[1023] = 1;
    drain();

    // register extremes then random traffic
    write_reg(CFG_STEP_DURATION, 31'd0);
    write_reg(CFG_DEFAULT_USE, 31'h1ff_ffff);
    random_phase(150, 16);
    drain();
    write_reg(CFG_STEP_DURATION, 31'h7fff_ffff);
    write_reg(CFG_DEFAULT_USE, 31'd0);
    random_phase(150, 16);
    drain();
    write_reg(CFG_STEP_DURATION, 31'd1677);
    write_reg(CFG_DEFAULT_USE, 31'd8388608);
    stall_free = 400;
    random_phase(500, 64);
    drain();
    write_reg(CFG_STEP_DURATION, 31'(100000));
    write_reg(CFG_DEFAULT_USE, 31'(1 << 24));
    random_phase(380, 1024);
    drain();
    write_reg(CFG_STEP_DURATION, 31'($urandom_range(300000)));
    write_reg(CFG_DEFAULT_USE, 31'($urandom_range(1 << 24)));
    random_phase(350, 32);
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== dynamic_synapse_psr_update_core.f =====
design/dspu_pkg.sv
design/dspu_div.sv
design/dynamic_synapse_psr_update_core.sv
tb/dynamic_synapse_psr_update_core_test.sv
